// ===== src/bmp_pkg.sv =====
`timescale 1ns / 1ps
// bmp_pkg: shared types and constants of the block mean pixelation block
// field widths, register indexes, reset values and status structs
// no dependencies
package bmp_pkg;

	// payload field widths
	localparam int PIX_W      = 8;
	localparam int QUO_W      = 8;
	localparam int COORD_W    = 11;
	localparam int DIM_W      = 12;
	localparam int BS_W       = 7;

	// stream word widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	// apb port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

	// register reset values
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd512;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd512;
	localparam logic [BS_W-1:0]  RST_BLOCK_SIZE   = 7'd8;

	// tallest image the block accepts
	localparam int MAX_HEIGHT = 2048;

	// geometry checker status
	typedef struct packed {
		logic ready;
		logic ok;
	} geom_stat_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/bmp_ram.sv =====
`timescale 1ns / 1ps
// bmp_ram: generic single-port-write, single-port-read synchronous ram
// read data registered
// no dependencies
module bmp_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 2048
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bmp_geom.sv =====
`timescale 1ns / 1ps
// bmp_geom: checks image geometry against the block size, one bit per cycle
// computes width and height remainders by restoring steps, plus block area
// depends on bmp_pkg
module bmp_geom #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_BLOCK = 64,
	parameter int AREA_W    = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bmp_pkg::DIM_W-1:0] width,
	input  logic [bmp_pkg::DIM_W-1:0] height,
	input  logic [bmp_pkg::BS_W-1:0]  bsize,
	output bmp_pkg::geom_stat_t       stat,
	output logic [AREA_W-1:0]         area
);
	localparam int STEP_W = $clog2(bmp_pkg::DIM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(bmp_pkg::DIM_W - 1);

	logic                  busy_q;
	logic                  ok_q;
	logic [STEP_W-1:0]     step_q;
	logic [7:0]            remw_q, remh_q;
	logic [AREA_W-1:0]     area_q;

	logic [7:0]            remw_sh, remh_sh, remw_n, remh_n, bs_ext;
	logic [13:0]           sq;
	logic                  limits_ok;

	always_comb begin
		bs_ext  = {1'b0, bsize};
		remw_sh = {remw_q[6:0], width[step_q]};
		remh_sh = {remh_q[6:0], height[step_q]};
		remw_n  = (remw_sh >= bs_ext) ? remw_sh - bs_ext : remw_sh;
		remh_n  = (remh_sh >= bs_ext) ? remh_sh - bs_ext : remh_sh;
		sq      = {7'd0, bsize} * {7'd0, bsize};
		limits_ok = (bsize != '0) && (32'(bsize) <= 32'(MAX_BLOCK))
			&& (width != '0) && (32'(width) <= 32'(MAX_WIDTH))
			&& (height != '0) && (32'(height) <= 32'(bmp_pkg::MAX_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			ok_q   <= 1'b0;
			step_q <= LAST_STEP;
			remw_q <= '0;
			remh_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ok_q   <= 1'b0;
			step_q <= LAST_STEP;
			remw_q <= '0;
			remh_q <= '0;
		end else if (busy_q) begin
			remw_q <= remw_n;
			remh_q <= remh_n;
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
				ok_q   <= limits_ok && (remw_n == '0) && (remh_n == '0);
			end
		end
	end

	// area only used once geometry is ok, so no reset needed
	always_ff @(posedge clk) begin
		area_q <= AREA_W'(sq);
	end

	assign stat.ready = !busy_q;
	assign stat.ok    = ok_q;
	assign area       = area_q;

endmodule

// ===== src/bmp_div.sv =====
`timescale 1ns / 1ps
// bmp_div: three-lane restoring divider, one quotient bit per cycle
// quotient is the truncated mean sum / area, known to fit in eight bits
// depends on bmp_pkg
module bmp_div #(
	parameter int SUM_W  = 20,
	parameter int AREA_W = 13
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [AREA_W-1:0]                    area,
	input  logic [2:0][SUM_W-1:0]                sums,
	output bmp_pkg::div_stat_t                   stat,
	output logic [2:0][bmp_pkg::QUO_W-1:0]       means
);
	localparam int DW    = AREA_W + bmp_pkg::QUO_W;
	localparam int CNT_W = $clog2(bmp_pkg::QUO_W);

	logic                               busy_q;
	logic                               done_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [DW-1:0]                      dvs_q;
	logic [2:0][DW-1:0]                 rem_q;
	logic [2:0][bmp_pkg::QUO_W-1:0]     quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(bmp_pkg::QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath, three channels side by side
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= DW'({area, {(bmp_pkg::QUO_W - 1){1'b0}}});
			for (int ch = 0; ch < 3; ch++) begin
				rem_q[ch] <= DW'(sums[ch]);
				quo_q[ch] <= '0;
			end
		end else if (busy_q) begin
			dvs_q <= dvs_q >> 1;
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_q[ch] >= dvs_q) begin
					rem_q[ch] <= rem_q[ch] - dvs_q;
					quo_q[ch] <= {quo_q[ch][bmp_pkg::QUO_W-2:0], 1'b1};
				end else begin
					quo_q[ch] <= {quo_q[ch][bmp_pkg::QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign means     = quo_q;

endmodule

// ===== src/block_mean_pixelation.sv =====
`timescale 1ns / 1ps
// block_mean_pixelation: block-average pixelation of a raster rgb stream
// top level: position counters, sum memory read-modify-write, output register
// depends on bmp_pkg, bmp_ram, bmp_geom, bmp_div
//
//  channel   dir   word                                       handshake
//  s_axis    in    red, green, blue                           s_tvalid / s_tready
//  m_axis    out   means, block column/row + size_error flag  m_tvalid / m_tready
//  apb       in    image_width, image_height, block_size      psel & penable, pready = 1
//
// a pixel is accepted with the sum read issued, then read-modify-written;
// a pixel that completes a block then takes eight divider steps, sees done
// and loads the output register; an error word is accepted, then loaded
// reset and each write to a listed register start a geometry check,
// s_tready stays low until it is done
// a finished word waits in the output register; only a pixel with its own result stalls
module block_mean_pixelation #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_BLOCK = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bmp_pkg::IN_DATA_W-1:0]      s_tdata,   // red_in, green_in, blue_in
	// block result output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bmp_pkg::OUT_DATA_W-1:0]     m_tdata,   // avg_red, avg_green, avg_blue,
	                                                      // block_column, block_row, zero pad
	output logic                               m_tuser,   // size_error
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bmp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bmp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bmp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SUM_W  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
	localparam int AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
	localparam int DIM_W  = bmp_pkg::DIM_W;
	localparam int BS_W   = bmp_pkg::BS_W;
	localparam int PIX_W  = bmp_pkg::PIX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RMW,
		S_DIV,
		S_OUT
	} state_t;

	// configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic [BS_W-1:0]  bs_q;
	logic             cfg_wr, cfg_hit;

	// position counters
	logic [DIM_W-1:0] pc_q, pr_q, cbc_q, cbr_q;
	logic [BS_W-1:0]  cib_q, rib_q;

	// fsm and pipeline
	state_t                    state_q;
	logic                      err_q;
	logic [2:0][PIX_W-1:0]     pix_s1;
	logic [bmp_pkg::COORD_W-1:0] col_s2, row_s2;

	// output register
	logic                              m_tvalid_q;
	logic [bmp_pkg::OUT_DATA_W-1:0]    m_tdata_q;
	logic                              m_tuser_q;

	// memory and helpers
	logic [3*SUM_W-1:0]        ram_rdata, ram_wdata;
	logic                      ram_we;
	logic [2:0][SUM_W-1:0]     sum_old, sum_new;
	logic                      s_accept, out_free, first_px, blk_last, div_start;
	logic [BS_W:0]             cib_inc, rib_inc;
	logic [DIM_W:0]            pc_inc, pr_inc;

	bmp_pkg::geom_stat_t       gstat;
	bmp_pkg::div_stat_t        dstat;
	logic [AREA_W-1:0]         area;
	logic [2:0][bmp_pkg::QUO_W-1:0] means;

	//------------------------------------------------------------------
	// apb configuration, register index in paddr[3:2]
	//------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_hit = cfg_wr && (paddr[3:2] == bmp_pkg::REG_IMAGE_WIDTH
		|| paddr[3:2] == bmp_pkg::REG_IMAGE_HEIGHT
		|| paddr[3:2] == bmp_pkg::REG_BLOCK_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmp_pkg::RST_IMAGE_WIDTH;
			height_q <= bmp_pkg::RST_IMAGE_HEIGHT;
			bs_q     <= bmp_pkg::RST_BLOCK_SIZE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bmp_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				bmp_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				bmp_pkg::REG_BLOCK_SIZE:   bs_q     <= pwdata[BS_W-1:0];
				default: ;   // beyond the register list, ignored
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bmp_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			bmp_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			bmp_pkg::REG_BLOCK_SIZE:   prdata = 32'(bs_q);
			default:                   prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// geometry check, rerun after every write to a listed register
	//------------------------------------------------------------------
	bmp_geom #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_BLOCK (MAX_BLOCK),
		.AREA_W    (AREA_W)
	) u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_hit),
		.width  (width_q),
		.height (height_q),
		.bsize  (bs_q),
		.stat   (gstat),
		.area   (area)
	);

	//------------------------------------------------------------------
	// input handshake; the sum entry of the current block column is read
	// at the accepting edge and written back in the following cycle
	//------------------------------------------------------------------
	assign s_tready = (state_q == S_IDLE) && gstat.ready && !cfg_wr;
	assign s_accept = s_tvalid && s_tready;

	bmp_ram #(
		.WIDTH (3 * SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cbc_q)),
		.wdata (ram_wdata),
		.re    (s_accept),
		.raddr (AW'(cbc_q)),
		.rdata (ram_rdata)
	);

	// modify: the top-left pixel of a block loads the sums, others add
	always_comb begin
		first_px = (cib_q == '0) && (rib_q == '0);
		for (int ch = 0; ch < 3; ch++) begin
			sum_old[ch] = ram_rdata[ch*SUM_W +: SUM_W];
			sum_new[ch] = first_px ? SUM_W'(pix_s1[ch])
				: sum_old[ch] + SUM_W'(pix_s1[ch]);
		end
		ram_wdata = {sum_new[2], sum_new[1], sum_new[0]};
		ram_we    = (state_q == S_RMW);

		cib_inc  = {1'b0, cib_q} + 1'b1;
		rib_inc  = {1'b0, rib_q} + 1'b1;
		pc_inc   = {1'b0, pc_q} + 1'b1;
		pr_inc   = {1'b0, pr_q} + 1'b1;
		// bottom-right pixel of the block
		blk_last = (cib_inc == {1'b0, bs_q}) && (rib_inc == {1'b0, bs_q});
		div_start = (state_q == S_RMW) && blk_last;
	end

	//------------------------------------------------------------------
	// raster position, advanced once per summed pixel in the write-back cycle
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			pr_q  <= '0;
			cbc_q <= '0;
			cbr_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
		end else if (cfg_hit) begin
			// a write to a listed register restarts the frame, sums are kept
			pc_q  <= '0;
			pr_q  <= '0;
			cbc_q <= '0;
			cbr_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
		end else if (state_q == S_RMW) begin
			if (pc_inc >= {1'b0, width_q}) begin
				// end of image row
				pc_q  <= '0;
				cib_q <= '0;
				cbc_q <= '0;
				if (pr_inc >= {1'b0, height_q}) begin
					// end of frame
					pr_q  <= '0;
					rib_q <= '0;
					cbr_q <= '0;
				end else begin
					pr_q <= pr_inc[DIM_W-1:0];
					if (rib_inc >= {1'b0, bs_q}) begin
						rib_q <= '0;
						cbr_q <= cbr_q + 1'b1;
					end else begin
						rib_q <= rib_inc[BS_W-1:0];
					end
				end
			end else begin
				pc_q <= pc_inc[DIM_W-1:0];
				if (cib_inc >= {1'b0, bs_q}) begin
					cib_q <= '0;
					cbc_q <= cbc_q + 1'b1;
				end else begin
					cib_q <= cib_inc[BS_W-1:0];
				end
			end
		end
	end

	// pixel and block coordinates held for the later stages
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pix_s1[0] <= s_tdata[7:0];
			pix_s1[1] <= s_tdata[15:8];
			pix_s1[2] <= s_tdata[23:16];
		end
		if (div_start) begin
			col_s2 <= cbc_q[bmp_pkg::COORD_W-1:0];
			row_s2 <= cbr_q[bmp_pkg::COORD_W-1:0];
		end
	end

	//------------------------------------------------------------------
	// mean of a finished block: sums divided by block_size squared
	//------------------------------------------------------------------
	bmp_div #(
		.SUM_W  (SUM_W),
		.AREA_W (AREA_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.area   (area),
		.sums   (sum_new),
		.stat   (dstat),
		.means  (means)
	);

	//------------------------------------------------------------------
	// sequencer and output register
	//------------------------------------------------------------------
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			err_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			// a word leaves on its handshake unless the sequencer reloads it now
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (gstat.ok) begin
							err_q   <= 1'b0;
							state_q <= S_RMW;
						end else begin
							// bad geometry: one error word per pixel, no update
							err_q   <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_RMW: begin
					state_q <= blk_last ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (dstat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= err_q;
						if (err_q) begin
							m_tdata_q <= '0;
						end else begin
							m_tdata_q <= {2'b00, row_s2, col_s2,
								means[2], means[1], means[0]};
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	//------------------------------------------------------------------
	// checks
	//------------------------------------------------------------------
	// a pixel is only taken with the sequencer idle and geometry settled
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |-> (state_q == S_IDLE) && gstat.ready)
		else $error("pixel accepted while busy");

	// the written entry is the one read at the accepting edge
	a_addr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMW) |-> $stable(cbc_q))
		else $error("sum address moved between read and write");

	// the divider is never restarted in flight
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !dstat.busy)
		else $error("divider restarted while busy");

	// an error word carries no means or coordinates
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error word with payload");

endmodule

// ===== sim/tb_block_mean_pixelation.sv =====
`timescale 1ns / 1ps
// tb_block_mean_pixelation: self-checking bench for the block mean pixelation block
// streams rgb pixels, programs the geometry over apb and checks every result word
// depends on bmp_pkg and block_mean_pixelation
module tb_block_mean_pixelation;
	localparam int PIX_W      = bmp_pkg::PIX_W;
	localparam int QUO_W      = bmp_pkg::QUO_W;
	localparam int COORD_W    = bmp_pkg::COORD_W;
	localparam int DIM_W      = bmp_pkg::DIM_W;
	localparam int BS_W       = bmp_pkg::BS_W;
	localparam int IN_DATA_W  = bmp_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = bmp_pkg::OUT_DATA_W;
	localparam int APB_ADDR_W = bmp_pkg::APB_ADDR_W;
	localparam int APB_DATA_W = bmp_pkg::APB_DATA_W;
	localparam int MAX_HEIGHT = bmp_pkg::MAX_HEIGHT;
	localparam logic [1:0] REG_IMAGE_WIDTH  = bmp_pkg::REG_IMAGE_WIDTH;
	localparam logic [1:0] REG_IMAGE_HEIGHT = bmp_pkg::REG_IMAGE_HEIGHT;
	localparam logic [1:0] REG_BLOCK_SIZE   = bmp_pkg::REG_BLOCK_SIZE;

	localparam int MAX_WIDTH     = 2048;
	localparam int MAX_BLOCK     = 64;
	localparam int SUM_W         = 20;
	// quiet time after the last result; ample margin over the pixel path, divider and output load
	localparam int QUIET_CYCLES  = 40;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_PIXELS = 400;
	// address decode has room for a fourth register that does not exist
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             wait_drain;
	} pixel_t;

	typedef struct packed {
		logic [QUO_W-1:0]   avg_red;
		logic [QUO_W-1:0]   avg_green;
		logic [QUO_W-1:0]   avg_blue;
		logic [COORD_W-1:0] block_column;
		logic [COORD_W-1:0] block_row;
		logic               size_error;
	} block_word_t;

	// every block input starts at a known value
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// pixels waiting to go out, block means waiting to come back
	pixel_t      pixel_queue[$];
	block_word_t expected_blocks[$];
	pixel_t      pixel_on_bus;
	block_word_t next_block;

	int fail_count      = 0;
	int send_gap        = 0;
	int recv_stall      = 0;
	int hold_left       = 0;
	int holds_requested = 0;
	int holds_taken     = 0;
	bit send_idle_on    = 1'b1;
	bit recv_idle_on    = 1'b1;

	// predictor copy of the configuration
	logic [DIM_W-1:0] img_width  = bmp_pkg::RST_IMAGE_WIDTH;
	logic [DIM_W-1:0] img_height = bmp_pkg::RST_IMAGE_HEIGHT;
	logic [BS_W-1:0]  blk_size   = bmp_pkg::RST_BLOCK_SIZE;

	// predictor copy of the running sums and the raster position
	logic [SUM_W-1:0]   red_sum   [MAX_WIDTH];
	logic [SUM_W-1:0]   green_sum [MAX_WIDTH];
	logic [SUM_W-1:0]   blue_sum  [MAX_WIDTH];
	logic [DIM_W-1:0]   px_col     = '0;
	logic [DIM_W-1:0]   px_row     = '0;
	logic [BS_W-1:0]    col_in_blk = '0;
	logic [BS_W-1:0]    row_in_blk = '0;
	logic [COORD_W-1:0] blk_col    = '0;
	logic [COORD_W-1:0] blk_row    = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	block_mean_pixelation #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_BLOCK(MAX_BLOCK)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // red_in, green_in, blue_in
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // avg_red, avg_green, avg_blue, block_column, block_row
		.m_tuser(m_tuser),     // size_error
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// a write to any listed register sends the raster position back to the frame start
	function automatic void restart_frame();
		px_col     = '0;
		px_row     = '0;
		col_in_blk = '0;
		row_in_blk = '0;
		blk_col    = '0;
		blk_row    = '0;
	endfunction

	function automatic bit geometry_valid();
		if (blk_size == 0 || blk_size > MAX_BLOCK)
			return 1'b0;
		if (img_width == 0 || img_width > MAX_WIDTH)
			return 1'b0;
		if (img_height == 0 || img_height > MAX_HEIGHT)
			return 1'b0;
		return (img_width % blk_size == 0) && (img_height % blk_size == 0);
	endfunction

	// advance the predictor by one accepted pixel, queue the block mean it completes or its error word
	function automatic void account_pixel(input pixel_t px);
		block_word_t res;
		logic [12:0] area;
		int          idx;
		res = '0;
		// bad geometry: one error word per pixel, position and sums frozen
		if (!geometry_valid()) begin
			res.size_error = 1'b1;
			expected_blocks.push_back(res);
			return;
		end
		idx = int'(blk_col);
		// top-left pixel of a block starts the column's sums afresh
		if (col_in_blk == 0 && row_in_blk == 0) begin
			red_sum[idx]   = SUM_W'(px.red);
			green_sum[idx] = SUM_W'(px.green);
			blue_sum[idx]  = SUM_W'(px.blue);
		end else begin
			red_sum[idx]   = red_sum[idx] + SUM_W'(px.red);
			green_sum[idx] = green_sum[idx] + SUM_W'(px.green);
			blue_sum[idx]  = blue_sum[idx] + SUM_W'(px.blue);
		end
		// bottom-right pixel closes the block
		if (col_in_blk == blk_size - 1 && row_in_blk == blk_size - 1) begin
			area             = 13'(blk_size) * 13'(blk_size);
			res.avg_red      = QUO_W'(red_sum[idx] / area);
			res.avg_green    = QUO_W'(green_sum[idx] / area);
			res.avg_blue     = QUO_W'(blue_sum[idx] / area);
			res.block_column = blk_col;
			res.block_row    = blk_row;
			expected_blocks.push_back(res);
		end
		col_in_blk++;
		if (col_in_blk >= blk_size) begin
			col_in_blk = '0;
			blk_col++;
		end
		px_col++;
		// end of row, then end of band, then end of frame
		if (px_col >= img_width) begin
			px_col     = '0;
			col_in_blk = '0;
			blk_col    = '0;
			row_in_blk++;
			if (row_in_blk >= blk_size) begin
				row_in_blk = '0;
				blk_row++;
			end
			px_row++;
			if (px_row >= img_height)
				restart_frame();
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] expected,
			input logic [15:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			fail_count++;
		end
	endfunction

	// extreme channel values show up often among the random ones
	function automatic logic [PIX_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_pixel(input int r, input int g, input int b);
		pixel_queue.push_back('{red: PIX_W'(r), green: PIX_W'(g), blue: PIX_W'(b),
			wait_drain: 1'b0});
	endfunction

	// random content; now and then a word makes the sender wait for all results
	function automatic void add_random_pixels(input int count);
		pixel_t px;
		repeat (count) begin
			px.red        = random_channel();
			px.green      = random_channel();
			px.blue       = random_channel();
			px.wait_drain = ($urandom_range(0, 63) == 0);
			pixel_queue.push_back(px);
		end
	endfunction

	// garbage above the register field must be dropped by the block
	function automatic logic [APB_DATA_W-1:0] with_junk(input int value, input int field_w);
		logic [APB_DATA_W-1:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
		return (junk << field_w) | value;
	endfunction

	// setup cycle, access cycle; the register takes the value at the access edge
	task automatic write_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  img_width  = value[DIM_W-1:0];
			REG_IMAGE_HEIGHT: img_height = value[DIM_W-1:0];
			REG_BLOCK_SIZE:   blk_size   = value[BS_W-1:0];
			default: ;
		endcase
		if (idx != REG_UNMAPPED)
			restart_frame();
		@(negedge clk);
	endtask

	// read back a register and compare against the predictor's copy
	task automatic read_register(input logic [1:0] idx);
		logic [APB_DATA_W-1:0] expected;
		case (idx)
			REG_IMAGE_WIDTH:  expected = APB_DATA_W'(img_width);
			REG_IMAGE_HEIGHT: expected = APB_DATA_W'(img_height);
			REG_BLOCK_SIZE:   expected = APB_DATA_W'(blk_size);
			default:          expected = '0;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== expected) begin
			$error("prdata of register %0d: expected %0d, got %0d", idx, expected, prdata);
			fail_count++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// all pixels taken, all results back, then let the pipeline settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || s_tvalid || expected_blocks.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic set_geometry(input int w, input int h, input int bs);
		wait_idle();
		write_register(REG_IMAGE_WIDTH, with_junk(w, DIM_W));
		write_register(REG_IMAGE_HEIGHT, with_junk(h, DIM_W));
		write_register(REG_BLOCK_SIZE, with_junk(bs, BS_W));
		if ($urandom_range(0, 1)) begin
			read_register(REG_IMAGE_WIDTH);
			read_register(REG_IMAGE_HEIGHT);
			read_register(REG_BLOCK_SIZE);
		end
	endtask

	// pixel sender: one word per handshake, random gap after each accepted word when send_idle_on is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				account_pixel(pixel_on_bus);
				send_gap = send_idle_on ? $urandom_range(0, 10) : 0;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pixel_queue.size() != 0 &&
						!(pixel_queue[0].wait_drain && expected_blocks.size() != 0)) begin
					pixel_on_bus = pixel_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {pixel_on_bus.blue, pixel_on_bus.green, pixel_on_bus.red};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver: compares each word with the oldest predicted block mean
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
			hold_left  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_blocks.size() == 0) begin
					$error("unexpected word %h, size_error %b", m_tdata, m_tuser);
					fail_count++;
				end else begin
					next_block = expected_blocks.pop_front();
					check_field("avg_red", next_block.avg_red, m_tdata[0 +: QUO_W]);
					check_field("avg_green", next_block.avg_green, m_tdata[QUO_W +: QUO_W]);
					check_field("avg_blue", next_block.avg_blue, m_tdata[2*QUO_W +: QUO_W]);
					check_field("block_column", next_block.block_column,
						m_tdata[3*QUO_W +: COORD_W]);
					check_field("block_row", next_block.block_row,
						m_tdata[3*QUO_W+COORD_W +: COORD_W]);
					check_field("tdata pad", '0, m_tdata[OUT_DATA_W-1:3*QUO_W+2*COORD_W]);
					check_field("size_error", next_block.size_error, m_tuser);
				end
				recv_stall = recv_idle_on ? $urandom_range(0, 10) : 0;
			end
			// long back-pressure on request so the block fills up and stalls its input
			if (holds_taken != holds_requested) begin
				holds_taken = holds_requested;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int w;
		int h;
		int bs;
		int n;
		int part;
		int random_count;
		random_count = 0;
		restart_frame();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// registers come up at their reset values
		read_register(REG_IMAGE_WIDTH);
		read_register(REG_IMAGE_HEIGHT);
		read_register(REG_BLOCK_SIZE);

		// 2x2 image of one 2x2 block, two frames: truncation, then all-white
		set_geometry(2, 2, 2);
		add_pixel(255, 0, 1);
		add_pixel(255, 0, 1);
		add_pixel(255, 0, 1);
		add_pixel(254, 1, 0);
		repeat (4) add_pixel(255, 255, 255);

		// single-pixel blocks pass every pixel straight through
		set_geometry(1, 1, 1);
		add_pixel(8'h55, 8'haa, 8'h0f);
		add_pixel(8'haa, 8'h55, 8'hf0);
		add_pixel(0, 0, 0);

		// bad geometries: not a multiple, zero, and out of range
		set_geometry(4, 6, 4);
		add_pixel(1, 2, 3);
		set_geometry(6, 4, 4);
		add_pixel(4, 5, 6);
		set_geometry(4, 4, 0);
		add_pixel(255, 255, 255);
		set_geometry(127, 127, 127);
		add_pixel(7, 8, 9);
		set_geometry(0, 4, 1);
		add_pixel(10, 11, 12);
		set_geometry(4095, 4, 1);
		add_pixel(13, 14, 15);
		set_geometry(4, 0, 1);
		add_pixel(16, 17, 18);
		set_geometry(4, 4095, 1);
		add_pixel(19, 20, 21);

		// largest legal frame, cut short by the next write
		set_geometry(2048, 2048, 64);
		add_pixel(200, 100, 50);

		// full-width row of single-pixel blocks at full rate, with one long stall,
		// cut short by the next write
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		set_geometry(2048, 1, 1);
		holds_requested++;
		add_random_pixels(200);

		// full-height column of single-pixel blocks, also cut short
		set_geometry(1, 2048, 1);
		add_random_pixels(100);

		// one 16x16 block near the top of its sum range
		set_geometry(16, 16, 16);
		repeat (255) add_pixel(255, 255, 255);
		add_pixel(0, 128, 255);

		// sparse results: the output register holds one word while pixels keep coming
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		set_geometry(16, 8, 2);
		holds_requested++;
		add_random_pixels(128);

		// random geometries, mostly valid small frames, some broken ones
		while (random_count < RANDOM_PIXELS) begin
			if ($urandom_range(0, 4) == 0) begin
				bs = $urandom_range(0, 127);
				w  = $urandom_range(0, 4095);
				h  = $urandom_range(0, 4095);
				n  = $urandom_range(1, 6);
			end else begin
				bs = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
				w  = bs * $urandom_range(1, (bs > 8) ? 2 : 4);
				h  = bs * $urandom_range(1, (bs > 8) ? 2 : 3);
				n  = $urandom_range(w * h / 2 + 1, 2 * w * h);
				if (n > 120)
					n = 120;
			end
			set_geometry(w, h, bs);
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			if (n > 1 && $urandom_range(0, 3) == 0) begin
				// break the frame: a write to the missing register leaves the position
				// alone, rewriting block_size sends it back to the frame start
				part = $urandom_range(1, n - 1);
				add_random_pixels(part);
				wait_idle();
				if ($urandom_range(0, 1))
					write_register(REG_UNMAPPED, $urandom);
				else
					write_register(REG_BLOCK_SIZE, bs);
				add_random_pixels(n - part);
			end else begin
				add_random_pixels(n);
			end
			random_count += n;
		end

		wait_idle();
		if (fail_count == 0 && expected_blocks.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bmp_pkg.sv
src/bmp_ram.sv
src/bmp_geom.sv
src/bmp_div.sv
src/block_mean_pixelation.sv
sim/tb_block_mean_pixelation.sv
